### src/mwcs_pkg.sv
// Package for the Microwire EEPROM command store.
// Holds widths, action codes, sequencer states and store geometry.
// No dependencies.
package mwcs_pkg;

   localparam int ACTION_W    = 3;
   localparam int ADDR_W      = 7;
   localparam int DATA_W      = 16;
   localparam int BYTE_W      = 8;
   localparam int STORE_BYTES = 128;
   localparam int ROWS        = STORE_BYTES / 2;
   localparam int ROW_W       = $clog2(ROWS);
   localparam int BYTE_IDX_W  = $clog2(STORE_BYTES);

   localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);
   localparam logic [BYTE_W-1:0] ERASED_BYTE = '1;

   typedef enum logic [ACTION_W-1:0] {
      ACT_READ      = 3'd0,
      ACT_WRITE     = 3'd1,
      ACT_ERASE     = 3'd2,
      ACT_ENABLE    = 3'd3,
      ACT_DISABLE   = 3'd4,
      ACT_ERASE_ALL = 3'd5,
      ACT_WRITE_ALL = 3'd6
   } mwcs_action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FILL
   } mwcs_state_type;

endpackage

### src/mwcs_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on mwcs_pkg.
interface mwcs_req_if;
   import mwcs_pkg::*;

   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [ADDR_W-1:0]   address;
   logic [DATA_W-1:0]   write_value;

   modport source (output valid, output action, output address, output write_value,
                   input ready);
   modport sink   (input valid, input action, input address, input write_value,
                   output ready);
endinterface

interface mwcs_rsp_if;
   import mwcs_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_value;
   logic              status;

   modport source (output valid, output read_value, output status, input ready);
   modport sink   (input valid, input read_value, input status, output ready);
endinterface

### src/microwire_eeprom_command_store_core.sv
// Microwire EEPROM command store: 128-byte store, write-enable latch, sequencer.
// Depends on mwcs_pkg and the channel interfaces in mwcs_if.sv.
//
//  channel    dir  handshake     payload
//  req_chan   in   valid/ready   action, address, write_value
//  rsp_chan   out  valid/ready   read_value, status
//  csr_*      in   csr_we        csr_wdata (word organization)
//
// Write, erase, latch and erase-all items: result in the cycle after the accept. Read:
// registered read of the 64x16 store, then ST_READ registers the result. Write-all:
// ST_FILL writes one row per cycle through the store's single write port, then the result.
// Reset clears per-byte valid flops at once; an invalid byte reads as erased.
// req_chan.ready is low while a result waits and is not taken in that cycle.
module microwire_eeprom_command_store_core (
   input  logic         clock,
   input  logic         reset,
   mwcs_req_if.sink     req_chan,
   mwcs_rsp_if.source   rsp_chan,
   input  logic         csr_we,
   input  logic         csr_wdata
);
   import mwcs_pkg::*;

   mwcs_state_type           state_ff, state_in;
   logic                     wel_ff, wel_in;
   logic                     org_ff;
   logic [STORE_BYTES-1:0]   valid_ff, valid_in;

   logic [DATA_W-1:0]        mem [ROWS];
   logic                     mem_we_hi, mem_we_lo, mem_re;
   logic [ROW_W-1:0]         mem_waddr, mem_raddr;
   logic [DATA_W-1:0]        mem_wdata;
   logic [DATA_W-1:0]        rd_data_ff;

   logic [ROW_W-1:0]         op_row_ff, op_row_in;
   logic                     op_lo_ff, op_lo_in;
   logic [DATA_W-1:0]        fill_value_ff, fill_value_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]        rsp_value_ff, rsp_value_in;
   logic                     rsp_status_ff, rsp_status_in;

   logic                     accept;
   logic [ROW_W-1:0]         req_row;
   logic [BYTE_W-1:0]        rd_hi, rd_lo;

   assign req_chan.ready      = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept              = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.read_value = rsp_value_ff;
   assign rsp_chan.status     = rsp_status_ff;

   assign req_row = org_ff ? req_chan.address[ROW_W-1:0] : req_chan.address[ADDR_W-1:1];
   assign rd_hi   = valid_ff[{op_row_ff, 1'b0}] ? rd_data_ff[DATA_W-1:BYTE_W] : ERASED_BYTE;
   assign rd_lo   = valid_ff[{op_row_ff, 1'b1}] ? rd_data_ff[BYTE_W-1:0] : ERASED_BYTE;

   always_comb begin
      state_in      = state_ff;
      wel_in        = wel_ff;
      valid_in      = valid_ff;
      mem_we_hi     = 1'b0;
      mem_we_lo     = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = op_row_ff;
      mem_raddr     = req_row;
      mem_wdata     = fill_value_ff;
      op_row_in     = op_row_ff;
      op_lo_in      = op_lo_ff;
      fill_value_in = fill_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = 1'b0;
               unique case (mwcs_action_type'(req_chan.action))
                  ACT_READ: begin
                     mem_re       = 1'b1;
                     op_row_in    = req_row;
                     op_lo_in     = req_chan.address[0];
                     rsp_valid_in = 1'b0;
                     state_in     = ST_READ;
                  end
                  ACT_WRITE: begin
                     if (wel_ff) begin
                        mem_waddr = req_row;
                        if (org_ff) begin
                           mem_wdata                   = req_chan.write_value;
                           mem_we_hi                   = 1'b1;
                           mem_we_lo                   = 1'b1;
                           valid_in[{req_row, 1'b0}]   = 1'b1;
                           valid_in[{req_row, 1'b1}]   = 1'b1;
                        end else begin
                           mem_wdata = {req_chan.write_value[BYTE_W-1:0],
                                        req_chan.write_value[BYTE_W-1:0]};
                           mem_we_hi = !req_chan.address[0];
                           mem_we_lo = req_chan.address[0];
                           valid_in[req_chan.address] = 1'b1;
                        end
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  ACT_ERASE: begin
                     if (wel_ff) begin
                        if (org_ff) begin
                           valid_in[{req_row, 1'b0}] = 1'b0;
                           valid_in[{req_row, 1'b1}] = 1'b0;
                        end else begin
                           valid_in[req_chan.address] = 1'b0;
                        end
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  ACT_ENABLE: begin
                     wel_in = 1'b1;
                  end
                  ACT_DISABLE: begin
                     wel_in = 1'b0;
                  end
                  ACT_ERASE_ALL: begin
                     if (wel_ff) begin
                        valid_in = '0;
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  ACT_WRITE_ALL: begin
                     if (wel_ff) begin
                        fill_value_in = org_ff ? req_chan.write_value :
                                        {req_chan.write_value[BYTE_W-1:0],
                                         req_chan.write_value[BYTE_W-1:0]};
                        op_row_in     = '0;
                        rsp_valid_in  = 1'b0;
                        state_in      = ST_FILL;
                     end else begin
                        rsp_status_in = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = 1'b0;
            if (org_ff) begin
               rsp_value_in = {rd_hi, rd_lo};
            end else begin
               rsp_value_in = {{BYTE_W{1'b0}}, op_lo_ff ? rd_lo : rd_hi};
            end
            state_in = ST_IDLE;
         end
         ST_FILL: begin
            mem_we_hi                   = 1'b1;
            mem_we_lo                   = 1'b1;
            valid_in[{op_row_ff, 1'b0}] = 1'b1;
            valid_in[{op_row_ff, 1'b1}] = 1'b1;
            op_row_in                   = op_row_ff + 1'b1;
            if (op_row_ff == ROW_LAST) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = '0;
               rsp_status_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wel_ff       <= 1'b0;
         org_ff       <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wel_ff       <= wel_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            org_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_row_ff     <= op_row_in;
      op_lo_ff      <= op_lo_in;
      fill_value_ff <= fill_value_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we_hi) begin
         mem[mem_waddr][DATA_W-1:BYTE_W] <= mem_wdata[DATA_W-1:BYTE_W];
      end
      if (mem_we_lo) begin
         mem[mem_waddr][BYTE_W-1:0] <= mem_wdata[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

endmodule

### src/mwcs_checker.sv
// Port-level checks for the Microwire EEPROM command store, and their bind.
// Depends on mwcs_pkg and microwire_eeprom_command_store_core.
module mwcs_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [mwcs_pkg::ACTION_W-1:0] req_action,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [mwcs_pkg::DATA_W-1:0]   rsp_read_value,
   input logic                          rsp_status
);
   import mwcs_pkg::*;

   logic req_fire;
   logic req_quick;

   assign req_fire  = req_valid && req_ready;
   assign req_quick = (req_action != ACT_READ) && (req_action != ACT_WRITE_ALL);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_status))
      else $error("result item changed while stalled");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("item taken while a result waits");

   a_refused_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_read_value == '0)
      else $error("refused item carries read data");

   a_quick_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_quick |=> rsp_valid)
      else $error("single-cycle item gave no result");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind microwire_eeprom_command_store_core mwcs_checker u_mwcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_action     (req_chan.action),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_read_value (rsp_chan.read_value),
   .rsp_status     (rsp_chan.status)
);

### sim/tb_microwire_eeprom_command_store_core.sv
// Testbench for microwire_eeprom_command_store_core: a directed and a random command stream
// is checked against a mirror of the byte store and write-enable latch, with random stalls.
// Depends on mwcs_pkg, mwcs_if.sv (mwcs_req_if, mwcs_rsp_if) and the core RTL.
module tb_microwire_eeprom_command_store_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mwcs_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [ADDR_W-1:0]   address;
      logic [DATA_W-1:0]   write_value;
   } command_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_value;
      logic              status;
   } outcome_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   mwcs_req_if req_if ();
   mwcs_rsp_if rsp_if ();

   microwire_eeprom_command_store_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if.sink),
      .rsp_chan  (rsp_if.source),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   logic [BYTE_W-1:0] mirror_bytes [STORE_BYTES];
   logic              mirror_wel;
   logic              mirror_word_org;

   command_type pending_commands [$];
   outcome_type expected_outcomes [$];
   command_type next_cmd;

   int  error_count;
   int  cycle_count;
   int  req_gap;
   int  rsp_gap;
   bit  req_taken;
   bit  no_idle;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                  logic [DATA_W-1:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
               cycle_count);
      error_count++;
   endtask

   function automatic void store_entry(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] value);
      if (mirror_word_org) begin
         mirror_bytes[{addr[5:0], 1'b0}] = value[15:8];
         mirror_bytes[{addr[5:0], 1'b1}] = value[7:0];
      end else begin
         mirror_bytes[addr] = value[7:0];
      end
   endfunction

   function automatic void fill_store(logic [DATA_W-1:0] value);
      for (int i = 0; i < STORE_BYTES; i += 2) begin
         mirror_bytes[i]     = mirror_word_org ? value[15:8] : value[7:0];
         mirror_bytes[i + 1] = value[7:0];
      end
   endfunction

   function automatic outcome_type predict_outcome(command_type c);
      outcome_type o;
      o = '0;
      case (c.action)
         ACT_READ: begin
            if (mirror_word_org)
               o.read_value = {mirror_bytes[{c.address[5:0], 1'b0}],
                               mirror_bytes[{c.address[5:0], 1'b1}]};
            else
               o.read_value = {8'h00, mirror_bytes[c.address]};
         end
         ACT_WRITE: begin
            if (mirror_wel) store_entry(c.address, c.write_value);
            else o.status = 1'b1;
         end
         ACT_ERASE: begin
            if (mirror_wel) store_entry(c.address, 16'hFFFF);
            else o.status = 1'b1;
         end
         ACT_ENABLE:  mirror_wel = 1'b1;
         ACT_DISABLE: mirror_wel = 1'b0;
         ACT_ERASE_ALL: begin
            if (mirror_wel) fill_store(16'hFFFF);
            else o.status = 1'b1;
         end
         ACT_WRITE_ALL: begin
            if (mirror_wel) fill_store(c.write_value);
            else o.status = 1'b1;
         end
         default: ;
      endcase
      return o;
   endfunction

   function automatic command_type random_command();
      command_type c;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35)      c.action = ACT_READ;
      else if (pick < 60) c.action = ACT_WRITE;
      else if (pick < 70) c.action = ACT_ERASE;
      else if (pick < 80) c.action = ACT_ENABLE;
      else if (pick < 85) c.action = ACT_DISABLE;
      else if (pick < 88) c.action = ACT_ERASE_ALL;
      else if (pick < 91) c.action = ACT_WRITE_ALL;
      else if (pick < 94) c.action = ACT_UNUSED;
      else                c.action = ACT_READ;
      c.address = ADDR_W'($urandom_range(0, STORE_BYTES - 1));
      pick = $urandom_range(0, 9);
      if (pick == 0)      c.write_value = 16'h0000;
      else if (pick == 1) c.write_value = 16'hFFFF;
      else                c.write_value = DATA_W'($urandom);
      return c;
   endfunction

   task automatic push_cmd(logic [ACTION_W-1:0] act, logic [ADDR_W-1:0] addr,
                           logic [DATA_W-1:0] value);
      pending_commands.push_back({act, addr, value});
   endtask

   task automatic wait_idle();
      while (pending_commands.size() != 0 || req_if.valid || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_org(logic value);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      mirror_word_org = value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      for (int i = 0; i < count; i++)
         pending_commands.push_back(random_command());
   endtask

   // item driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap--;
         end else if (pending_commands.size() != 0) begin
            next_cmd = pending_commands.pop_front();
            req_if.valid <= 1'b1;
            req_if.action <= next_cmd.action;
            req_if.address <= next_cmd.address;
            req_if.write_value <= next_cmd.write_value;
            if (!no_idle && $urandom_range(0, 3) == 0)
               req_gap = $urandom_range(1, 3);
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // result sink stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_if.ready <= 1'b1;
         if (!no_idle && $urandom_range(0, 4) == 0)
            rsp_gap = $urandom_range(1, 3);
      end
   end

   // monitor: predict on accepted commands, check accepted results
   always @(posedge clock) begin
      outcome_type want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_microwire_eeprom_command_store_core: FAIL");
         $finish;
      end else begin
         req_taken = !reset && req_if.valid && req_if.ready;
         if (req_taken)
            expected_outcomes.push_back(predict_outcome({req_if.action, req_if.address,
                                                         req_if.write_value}));
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            if (expected_outcomes.size() == 0) begin
               report_mismatch("unexpected result", rsp_if.read_value, '0);
            end else begin
               want = expected_outcomes.pop_front();
               if (rsp_if.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_if.read_value, want.read_value);
               if (rsp_if.status !== want.status)
                  report_mismatch("status", 16'(rsp_if.status), 16'(want.status));
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      req_if.valid = 1'b0;
      req_if.action = '0;
      req_if.address = '0;
      req_if.write_value = '0;
      rsp_if.ready = 1'b0;
      error_count = 0;
      cycle_count = 0;
      req_gap = 0;
      rsp_gap = 0;
      req_taken = 1'b0;
      no_idle = 1'b0;
      mirror_wel = 1'b0;
      mirror_word_org = 1'b0;
      for (int i = 0; i < STORE_BYTES; i++)
         mirror_bytes[i] = ERASED_BYTE;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // byte organization: erased after reset, refusals, layout and fills
      write_org(1'b0);
      push_cmd(ACT_READ, 7'd0, 16'h0000);
      push_cmd(ACT_WRITE, 7'd5, 16'h1234);
      push_cmd(ACT_ERASE, 7'd5, 16'h0000);
      push_cmd(ACT_ERASE_ALL, 7'd0, 16'h0000);
      push_cmd(ACT_WRITE_ALL, 7'd0, 16'h0000);
      push_cmd(ACT_ENABLE, 7'd0, 16'h0000);
      push_cmd(ACT_WRITE, 7'd127, 16'hFFAA);
      push_cmd(ACT_READ, 7'd127, 16'h0000);
      push_cmd(ACT_WRITE, 7'd0, 16'h0055);
      push_cmd(ACT_ERASE, 7'd127, 16'h0000);
      push_cmd(ACT_READ, 7'd127, 16'hFFFF);
      push_cmd(ACT_UNUSED, 7'd127, 16'hFFFF);
      push_cmd(ACT_WRITE_ALL, 7'd0, 16'hA5C3);
      push_cmd(ACT_READ, 7'd64, 16'h0000);
      push_cmd(ACT_ERASE_ALL, 7'd0, 16'h0000);
      push_cmd(ACT_WRITE, 7'd1, 16'h0000);
      push_cmd(ACT_DISABLE, 7'd0, 16'h0000);
      push_cmd(ACT_WRITE, 7'd1, 16'hFFFF);
      push_cmd(ACT_READ, 7'd1, 16'h0000);

      // word organization: address bit 6 ignored, big-endian byte pairs
      write_org(1'b1);
      push_cmd(ACT_ENABLE, 7'd0, 16'h0000);
      push_cmd(ACT_WRITE, 7'h7F, 16'hBEEF);
      push_cmd(ACT_READ, 7'h3F, 16'h0000);
      push_cmd(ACT_READ, 7'h00, 16'h0000);
      push_cmd(ACT_WRITE_ALL, 7'd0, 16'h8001);
      push_cmd(ACT_ERASE, 7'd10, 16'h0000);
      push_cmd(ACT_READ, 7'd10, 16'h0000);
      push_cmd(ACT_READ, 7'd11, 16'h0000);
      push_cmd(ACT_DISABLE, 7'd0, 16'h0000);
      push_cmd(ACT_ERASE_ALL, 7'd0, 16'h0000);
      push_cmd(ACT_READ, 7'h40, 16'h0000);

      write_org(1'b0);
      random_phase(100);
      write_org(1'b1);
      random_phase(100);
      write_org(1'b0);
      random_phase(100);
      wait_idle();
      no_idle = 1'b1;
      write_org(1'b1);
      random_phase(100);
      wait_idle();

      if (expected_outcomes.size() != 0)
         report_mismatch("results missing", 16'(expected_outcomes.size()), '0);
      if (error_count == 0) begin
         $display("tb_microwire_eeprom_command_store_core: PASS");
      end else begin
         $display("tb_microwire_eeprom_command_store_core: FAIL");
      end
      $finish;
   end
endmodule
